/* src/obstacle_avoid_drive_sequencer_macros.svh */
// Assertion macros for the drive sequencer.
// OADS_ASSERT_IMP: same-cycle implication. OADS_ASSERT_NXT: next-cycle implication.
`ifndef OBSTACLE_AVOID_DRIVE_SEQUENCER_MACROS_SVH
`define OBSTACLE_AVOID_DRIVE_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
`define OADS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define OADS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define OADS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define OADS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* src/oads_pkg.sv */
`timescale 1ns / 1ps

package oads_pkg;

   localparam int unsigned DIST_W  = 13;
   localparam int unsigned LVL_W   = 8;
   localparam int unsigned HOLD_W  = 11;
   localparam int unsigned DRV_W   = 2;
   localparam int unsigned CNT_W   = 8;
   localparam int unsigned LANES   = 3;
   localparam int unsigned SLOTS   = 13;
   localparam int unsigned SLOT_W  = 4;

   // wheel drive codes
   localparam logic [DRV_W-1:0] DRIVE_OFF = 2'd0;
   localparam logic [DRV_W-1:0] DRIVE_FWD = 2'd1;
   localparam logic [DRV_W-1:0] DRIVE_REV = 2'd2;

   // turn choice of a lane
   localparam logic [1:0] TURN_BEFORE = 2'd0;
   localparam logic [1:0] TURN_AFTER  = 2'd1;
   localparam logic [1:0] TURN_SPIN   = 2'd2;

   // command slots: lane i owns 3i (back-off), 3i+1 (turn), 3i+2 (spin second half)
   localparam logic [SLOT_W-1:0] SLOT_ESC_A  = 4'd9;
   localparam logic [SLOT_W-1:0] SLOT_ESC_B  = 4'd10;
   localparam logic [SLOT_W-1:0] SLOT_ESC_C  = 4'd11;
   localparam logic [SLOT_W-1:0] SLOT_FINAL  = 4'd12;

   localparam logic [HOLD_W-1:0] HOLD_STEP   = 11'd1000;
   localparam logic [HOLD_W-1:0] HOLD_LONG   = 11'd2000;
   localparam logic [HOLD_W-1:0] HOLD_NONE   = 11'd0;
   localparam logic [LVL_W-1:0]  ESCAPE_LVL  = 8'd255;
   localparam logic [CNT_W-1:0]  LOOP_MAX    = 8'd255;

   // register indexes
   localparam logic [2:0] REG_DETECT_SIDE  = 3'd0;
   localparam logic [2:0] REG_DETECT_FRONT = 3'd1;
   localparam logic [2:0] REG_CONTACT      = 3'd2;
   localparam logic [2:0] REG_OPEN_SPACE   = 3'd3;
   localparam logic [2:0] REG_LEFT_START   = 3'd4;
   localparam logic [2:0] REG_ESCAPE       = 3'd5;
   localparam logic [2:0] REG_RIGHT_SPEED  = 3'd6;
   localparam logic [2:0] REG_LEFT_SPEED   = 3'd7;

   typedef struct packed {
      logic [DIST_W-1:0] detect_side;
      logic [DIST_W-1:0] detect_front;
      logic [DIST_W-1:0] contact;
      logic [DIST_W-1:0] open_space;
      logic [CNT_W-1:0]  left_start;
      logic [CNT_W-1:0]  escape_cnt;
      logic [LVL_W-1:0]  right_speed;
      logic [LVL_W-1:0]  left_speed;
   } cfg_type;

   typedef struct packed {
      logic       contact;
      logic       detect;
      logic [1:0] sel;
   } lane_type;

   typedef struct packed {
      logic [SLOTS-1:0]            pending;
      logic [LANES-1:0][1:0]       sel;
      logic [DRV_W-1:0]            final_ld;
      logic [DRV_W-1:0]            final_rd;
   } job_type;

   typedef struct packed {
      logic [HOLD_W-1:0] hold;
      logic              brush;
      logic [LVL_W-1:0]  rl;
      logic [DRV_W-1:0]  rd;
      logic [LVL_W-1:0]  ll;
      logic [DRV_W-1:0]  ld;
   } cmd_type;

endpackage

/* src/oads_lane.sv */
`timescale 1ns / 1ps

// One sensor: contact / detect tests and choice of the clear neighbour.
module oads_lane (
   input  logic [oads_pkg::DIST_W-1:0] dist_own,
   input  logic [oads_pkg::DIST_W-1:0] thr_own,
   input  logic [oads_pkg::DIST_W-1:0] dist_before,
   input  logic [oads_pkg::DIST_W-1:0] thr_before,
   input  logic [oads_pkg::DIST_W-1:0] dist_after,
   input  logic [oads_pkg::DIST_W-1:0] thr_after,
   input  logic [oads_pkg::DIST_W-1:0] contact_mm,
   output oads_pkg::lane_type          result
);

   always_comb begin
      result.contact = dist_own < contact_mm;
      result.detect  = dist_own < thr_own;
      if (dist_before > thr_before) begin
         result.sel = oads_pkg::TURN_BEFORE;
      end else if (dist_after > thr_after) begin
         result.sel = oads_pkg::TURN_AFTER;
      end else begin
         result.sel = oads_pkg::TURN_SPIN;
      end
   end

endmodule

/* src/oads_merge.sv */
`timescale 1ns / 1ps

// Merges the lane results into a job descriptor; owns mode and loop count.
module oads_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  oads_pkg::lane_type [oads_pkg::LANES-1:0] lanes,
   input  logic [oads_pkg::DIST_W-1:0]          left_mm,
   input  logic [oads_pkg::DIST_W-1:0]          front_mm,
   input  logic [oads_pkg::DIST_W-1:0]          right_mm,
   input  oads_pkg::cfg_type                    cfg,
   output oads_pkg::job_type                    job
);

   logic                        cycle_mode_ff, cycle_mode_in;
   logic [oads_pkg::CNT_W-1:0]  loop_count_ff, loop_count_in;
   logic [oads_pkg::CNT_W-1:0]  lc_mid, lc_after;
   logic                        detect_any, all_open, escape;

   always_comb begin
      detect_any = lanes[0].detect | lanes[1].detect | lanes[2].detect;
      all_open   = (left_mm > cfg.open_space) && (front_mm > cfg.open_space) &&
                   (right_mm > cfg.open_space);

      cycle_mode_in = cycle_mode_ff;
      lc_mid        = loop_count_ff;
      job.final_ld  = oads_pkg::DRIVE_FWD;
      job.final_rd  = oads_pkg::DRIVE_FWD;
      if (detect_any) begin
         cycle_mode_in = 1'b0;
         lc_mid        = '0;
         // the last lane that acted sets the motors; a back-off without detection
         // leaves the wheels backing away
         for (int i = 0; i < oads_pkg::LANES; i++) begin
            if (lanes[i].detect) begin
               job.final_ld = oads_pkg::DRIVE_FWD;
               job.final_rd = oads_pkg::DRIVE_FWD;
            end else if (lanes[i].contact) begin
               job.final_ld = (i == 0) ? oads_pkg::DRIVE_OFF : oads_pkg::DRIVE_REV;
               job.final_rd = (i == 2) ? oads_pkg::DRIVE_OFF : oads_pkg::DRIVE_REV;
            end
         end
      end else begin
         if (!cycle_mode_ff && all_open) begin
            cycle_mode_in = 1'b1;
            lc_mid        = '0;
         end
         if (cycle_mode_in && (lc_mid < cfg.left_start)) begin
            job.final_ld = oads_pkg::DRIVE_OFF;
         end
      end

      escape   = lc_mid > cfg.escape_cnt;
      lc_after = escape ? '0 : lc_mid;
      if (escape) begin
         job.final_ld = oads_pkg::DRIVE_REV;
         job.final_rd = oads_pkg::DRIVE_FWD;
      end
      loop_count_in = (lc_after != oads_pkg::LOOP_MAX) ? lc_after + 8'd1 : lc_after;

      for (int i = 0; i < oads_pkg::LANES; i++) begin
         job.pending[3*i]   = lanes[i].contact;
         job.pending[3*i+1] = lanes[i].detect;
         job.pending[3*i+2] = lanes[i].detect && (lanes[i].sel == oads_pkg::TURN_SPIN);
         job.sel[i]         = lanes[i].sel;
      end
      job.pending[oads_pkg::SLOT_ESC_A] = escape;
      job.pending[oads_pkg::SLOT_ESC_B] = escape;
      job.pending[oads_pkg::SLOT_ESC_C] = escape;
      job.pending[oads_pkg::SLOT_FINAL] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_mode_ff <= 1'b0;
         loop_count_ff <= '0;
      end else if (accept) begin
         cycle_mode_ff <= cycle_mode_in;
         loop_count_ff <= loop_count_in;
      end
   end

endmodule

/* src/oads_emit.sv */
`timescale 1ns / 1ps
`include "obstacle_avoid_drive_sequencer_macros.svh"

// Holds one job, walks its pending slots lowest first, one word per cycle while rsp_ready allows.
module oads_emit (
   input  logic               clock,
   input  logic               reset,
   input  oads_pkg::cfg_type  cfg,
   input  oads_pkg::job_type  job_new,
   input  logic               accept,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output oads_pkg::cmd_type  rsp_cmd,
   output logic               rsp_last
);

   localparam logic [1:0] PH_BACK  = 2'd0;
   localparam logic [1:0] PH_TURN  = 2'd1;
   localparam logic [1:0] PH_SPIN2 = 2'd2;

   oads_pkg::job_type           job_ff, job_in;
   oads_pkg::cmd_type           cmd_ff, cmd_in;
   logic                        valid_ff, valid_in;
   logic                        last_ff, last_in;
   logic [oads_pkg::SLOTS-1:0]  low_bit, pending_after;
   logic [oads_pkg::SLOT_W-1:0] slot;
   logic                        load;
   logic [1:0]                  lane, phase, dir;
   logic [oads_pkg::DRV_W-1:0]  ld, rd;
   logic                        brush;
   logic [oads_pkg::HOLD_W-1:0] hold;
   logic                        esc_level;

   // neighbour directions: left wraps to right
   function automatic logic [1:0] before_of(input logic [1:0] l);
      case (l)
         2'd0:    before_of = 2'd2;
         2'd1:    before_of = 2'd0;
         default: before_of = 2'd1;
      endcase
   endfunction

   function automatic logic [1:0] after_of(input logic [1:0] l);
      case (l)
         2'd0:    after_of = 2'd1;
         2'd1:    after_of = 2'd2;
         default: after_of = 2'd0;
      endcase
   endfunction

   always_comb begin
      low_bit = job_ff.pending & (~job_ff.pending + 13'd1);
      slot    = '0;
      for (int i = 0; i < oads_pkg::SLOTS; i++) begin
         if (low_bit[i]) slot = oads_pkg::SLOT_W'(i);
      end
      load          = (job_ff.pending != '0) && (!valid_ff || rsp_ready);
      pending_after = load ? (job_ff.pending & ~low_bit) : job_ff.pending;
      free          = pending_after == '0;
   end

   // command for the selected slot
   always_comb begin
      lane      = 2'd0;
      phase     = PH_BACK;
      dir       = 2'd1;
      ld        = oads_pkg::DRIVE_FWD;
      rd        = oads_pkg::DRIVE_FWD;
      brush     = 1'b1;
      hold      = oads_pkg::HOLD_STEP;
      esc_level = 1'b0;
      last_in   = 1'b0;
      if (slot < 4'd3) begin
         lane  = 2'd0;
         phase = slot[1:0];
      end else if (slot < 4'd6) begin
         lane  = 2'd1;
         phase = 2'(slot - 4'd3);
      end else begin
         lane  = 2'd2;
         phase = 2'(slot - 4'd6);
      end

      case (slot)
         oads_pkg::SLOT_ESC_A: begin
            ld = oads_pkg::DRIVE_REV; rd = oads_pkg::DRIVE_REV;
            brush = 1'b0; hold = oads_pkg::HOLD_LONG; esc_level = 1'b1;
         end
         oads_pkg::SLOT_ESC_B: begin
            ld = oads_pkg::DRIVE_REV; rd = oads_pkg::DRIVE_REV; brush = 1'b0;
         end
         oads_pkg::SLOT_ESC_C: begin
            ld = oads_pkg::DRIVE_REV; rd = oads_pkg::DRIVE_FWD; brush = 1'b0;
         end
         oads_pkg::SLOT_FINAL: begin
            ld = job_ff.final_ld; rd = job_ff.final_rd;
            hold = oads_pkg::HOLD_NONE; last_in = 1'b1;
         end
         default: begin
            case (phase)
               PH_BACK: begin
                  // back away from the touching side
                  ld = (lane == 2'd0) ? oads_pkg::DRIVE_OFF : oads_pkg::DRIVE_REV;
                  rd = (lane == 2'd2) ? oads_pkg::DRIVE_OFF : oads_pkg::DRIVE_REV;
               end
               PH_TURN: begin
                  if (job_ff.sel[lane] == oads_pkg::TURN_SPIN) begin
                     ld = oads_pkg::DRIVE_REV; rd = oads_pkg::DRIVE_REV;
                  end else begin
                     dir = (job_ff.sel[lane] == oads_pkg::TURN_BEFORE) ?
                           before_of(lane) : after_of(lane);
                     ld  = (dir == 2'd0) ? oads_pkg::DRIVE_OFF : oads_pkg::DRIVE_FWD;
                     rd  = (dir == 2'd2) ? oads_pkg::DRIVE_OFF : oads_pkg::DRIVE_FWD;
                  end
               end
               default: begin
                  ld = oads_pkg::DRIVE_REV; rd = oads_pkg::DRIVE_FWD;
                  hold = oads_pkg::HOLD_LONG;
               end
            endcase
         end
      endcase

      cmd_in.ld    = ld;
      cmd_in.rd    = rd;
      cmd_in.ll    = (ld == oads_pkg::DRIVE_OFF) ? '0 :
                     (esc_level ? oads_pkg::ESCAPE_LVL : cfg.left_speed);
      cmd_in.rl    = (rd == oads_pkg::DRIVE_OFF) ? '0 :
                     (esc_level ? oads_pkg::ESCAPE_LVL : cfg.right_speed);
      cmd_in.brush = brush;
      cmd_in.hold  = hold;
   end

   always_comb begin
      job_in         = job_ff;
      job_in.pending = pending_after;
      if (accept) job_in = job_new;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         job_ff   <= job_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff  <= cmd_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_cmd   = cmd_ff;
   assign rsp_last  = last_ff;

   `OADS_ASSERT_IMP(a_final_pending, clock, reset, job_ff.pending != '0, job_ff.pending[oads_pkg::SLOT_FINAL], "busy job lost its final word")
   `OADS_ASSERT_IMP(a_escape_whole, clock, reset, job_ff.pending[oads_pkg::SLOT_ESC_A], job_ff.pending[oads_pkg::SLOT_ESC_B] && job_ff.pending[oads_pkg::SLOT_ESC_C], "escape slots out of step")
   `OADS_ASSERT_NXT(a_accept_busy, clock, reset, accept, job_ff.pending != '0, "accepted item left no job")

endmodule

/* src/obstacle_avoid_drive_sequencer.sv */
`timescale 1ns / 1ps

// Obstacle-avoid drive sequencer. Each req word carries left, front and right distances; the
// block answers with a run of 1 to 10 rsp words, each a full wheel/brush snapshot with its hold
// time, the last one flagged by rsp_tlast (hold 0). Three sensor lanes test contact, detect and
// clear neighbours side by side; a merge stage turns their findings into a list of pending
// command slots and updates the normal/cycle mode and loop count; an emitter sends one word per
// cycle from that list while rsp_tready is high. A taken req word's job is first registered in
// the emitter, and its words then move one by one into the output register. The next req word
// is taken in the cycle the final word of the current run moves into the output register, not
// before, so runs follow one another without a gap. Registers sit on the APB port at byte
// addresses 0x00..0x1C and must only be written while idle.
module obstacle_avoid_drive_sequencer (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [12:0] left_mm, [25:13] front_mm, [38:26] right_mm, [39] 0
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] left_drive, [9:2] left_level, [11:10] right_drive, [19:12] right_level,
   // [20] brush_on, [31:21] hold_ms
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,   // last
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   oads_pkg::cfg_type                       cfg_ff;
   oads_pkg::lane_type [oads_pkg::LANES-1:0] lanes;
   oads_pkg::job_type                       job_new;
   oads_pkg::cmd_type                       cmd;
   logic [oads_pkg::DIST_W-1:0]             left_mm, front_mm, right_mm;
   logic [2:0]                              reg_idx;
   logic                                    csr_write, accept, free;

   assign left_mm  = req_tdata[12:0];
   assign front_mm = req_tdata[25:13];
   assign right_mm = req_tdata[38:26];

   // ---- register file ----
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_side  <= 13'd120;
         cfg_ff.detect_front <= 13'd170;
         cfg_ff.contact      <= 13'd90;
         cfg_ff.open_space   <= 13'd1000;
         cfg_ff.left_start   <= 8'd30;
         cfg_ff.escape_cnt   <= 8'd200;
         cfg_ff.right_speed  <= 8'd180;
         cfg_ff.left_speed   <= 8'd220;
      end else if (csr_write) begin
         case (reg_idx)
            oads_pkg::REG_DETECT_SIDE:  cfg_ff.detect_side  <= csr_pwdata[12:0];
            oads_pkg::REG_DETECT_FRONT: cfg_ff.detect_front <= csr_pwdata[12:0];
            oads_pkg::REG_CONTACT:      cfg_ff.contact      <= csr_pwdata[12:0];
            oads_pkg::REG_OPEN_SPACE:   cfg_ff.open_space   <= csr_pwdata[12:0];
            oads_pkg::REG_LEFT_START:   cfg_ff.left_start   <= csr_pwdata[7:0];
            oads_pkg::REG_ESCAPE:       cfg_ff.escape_cnt   <= csr_pwdata[7:0];
            oads_pkg::REG_RIGHT_SPEED:  cfg_ff.right_speed  <= csr_pwdata[7:0];
            default:                    cfg_ff.left_speed   <= csr_pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         oads_pkg::REG_DETECT_SIDE:  csr_prdata = {19'd0, cfg_ff.detect_side};
         oads_pkg::REG_DETECT_FRONT: csr_prdata = {19'd0, cfg_ff.detect_front};
         oads_pkg::REG_CONTACT:      csr_prdata = {19'd0, cfg_ff.contact};
         oads_pkg::REG_OPEN_SPACE:   csr_prdata = {19'd0, cfg_ff.open_space};
         oads_pkg::REG_LEFT_START:   csr_prdata = {24'd0, cfg_ff.left_start};
         oads_pkg::REG_ESCAPE:       csr_prdata = {24'd0, cfg_ff.escape_cnt};
         oads_pkg::REG_RIGHT_SPEED:  csr_prdata = {24'd0, cfg_ff.right_speed};
         default:                    csr_prdata = {24'd0, cfg_ff.left_speed};
      endcase
   end

   // ---- sensor lanes: neighbour before / after, left's before wraps to right ----
   oads_lane u_lane_left (
      .dist_own    (left_mm),  .thr_own    (cfg_ff.detect_side),
      .dist_before (right_mm), .thr_before (cfg_ff.detect_side),
      .dist_after  (front_mm), .thr_after  (cfg_ff.detect_front),
      .contact_mm  (cfg_ff.contact),
      .result      (lanes[0])
   );

   oads_lane u_lane_front (
      .dist_own    (front_mm), .thr_own    (cfg_ff.detect_front),
      .dist_before (left_mm),  .thr_before (cfg_ff.detect_side),
      .dist_after  (right_mm), .thr_after  (cfg_ff.detect_side),
      .contact_mm  (cfg_ff.contact),
      .result      (lanes[1])
   );

   oads_lane u_lane_right (
      .dist_own    (right_mm), .thr_own    (cfg_ff.detect_side),
      .dist_before (front_mm), .thr_before (cfg_ff.detect_front),
      .dist_after  (left_mm),  .thr_after  (cfg_ff.detect_side),
      .contact_mm  (cfg_ff.contact),
      .result      (lanes[2])
   );

   // ---- merge: job descriptor and mode / loop state ----
   assign req_tready = free;
   assign accept     = req_tvalid && req_tready;

   oads_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .lanes    (lanes),
      .left_mm  (left_mm),
      .front_mm (front_mm),
      .right_mm (right_mm),
      .cfg      (cfg_ff),
      .job      (job_new)
   );

   // ---- emitter: one word per cycle from the pending slots while rsp_tready is high ----
   oads_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_new   (job_new),
      .accept    (accept),
      .free      (free),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_cmd   (cmd),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = cmd;

endmodule
